### hdl/texture_unit_lru_binder_defines.svh
// Assertion macros shared by the texture unit binder RTL.
`ifndef TEXTURE_UNIT_LRU_BINDER_DEFINES_SVH
`define TEXTURE_UNIT_LRU_BINDER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TULB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tulb: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TULB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tulb: next-cycle check failed");

`endif

### hdl/tulb_pkg.sv
`default_nettype none
package tulb_pkg;

    localparam int SAMPLER_W = 16;
    localparam int FILTER_W  = 3;
    localparam int CLAMP_W   = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_UNIT_W = 4;

    // Mode fields held by one binding, also used as the lookup key
    typedef struct packed {
        logic [SAMPLER_W-1:0] sampler;
        logic [FILTER_W-1:0]  filter;
        logic [CLAMP_W-1:0]   clamp_u;
        logic [CLAMP_W-1:0]   clamp_v;
    } t_mode;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_LOOK = 1'b1
    } t_state;

    // Take the default, else the texture's own value, else none/clamp
    function automatic logic [FILTER_W-1:0] resolve_mode(
        input logic [FILTER_W-1:0] dflt,
        input logic [FILTER_W-1:0] own
    );
        logic [FILTER_W-1:0] res;
        if (dflt != '0) begin
            res = dflt;
        end else if (own != '0) begin
            res = own;
        end else begin
            res = FILTER_W'(1);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### hdl/tulb_cell.sv
`default_nettype none
module tulb_cell #(
    parameter int UNIT_W     = 4,
    parameter int RESET_UNIT = 0,
    parameter bit IS_LAST    = 1'b0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_update,
    input  wire tulb_pkg::t_mode      i_key,
    input  wire logic                 i_found,
    input  wire tulb_pkg::t_mode      i_shift_mode,
    input  wire logic [UNIT_W-1:0]    i_shift_unit,
    input  wire tulb_pkg::t_mode      i_sel_mode,
    input  wire logic [UNIT_W-1:0]    i_sel_unit,
    output logic                      o_found,
    output tulb_pkg::t_mode           o_sel_mode,
    output logic [UNIT_W-1:0]         o_sel_unit,
    output tulb_pkg::t_mode           o_mode,
    output logic [UNIT_W-1:0]         o_unit
);
    import tulb_pkg::*;

    t_mode             r_mode;
    logic [UNIT_W-1:0] r_unit;
    logic              w_match;
    logic              w_take;

    // Null key matches any empty binding; a real key needs all fields equal
    assign w_match = (r_mode.sampler == i_key.sampler) &&
                     ((i_key.sampler == '0) ||
                      ((r_mode.filter  == i_key.filter)  &&
                       (r_mode.clamp_u == i_key.clamp_u) &&
                       (r_mode.clamp_v == i_key.clamp_v)));

    // First match claims the selection; the last cell also takes a miss
    assign w_take  = !i_found && (w_match || IS_LAST);
    assign o_found = i_found || w_match;

    // Fold this binding into the selection chain
    assign o_sel_mode = i_sel_mode | (w_take ? r_mode : t_mode'('0));
    assign o_sel_unit = i_sel_unit | (w_take ? r_unit : '0);

    assign o_mode = r_mode;
    assign o_unit = r_unit;

    // Shift down from the neighbor while the chosen rank is at or below us
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
            r_unit <= UNIT_W'(RESET_UNIT);
        end else if (i_update && !i_found) begin
            r_mode <= i_shift_mode;
            r_unit <= i_shift_unit;
        end
    end

endmodule
`default_nettype wire

### hdl/texture_unit_lru_binder.sv
// Texture unit binder with a most-recently-used ordered list of bindings.
// Input stream (i_s_axis_*): one request word per sampler bind, taken when
// tvalid and tready are both high. Output stream (o_m_axis_*): one result
// word per request, in request order.
// Each request is first latched with its modes resolved. Then every cell
// of the binding chain compares against the key, the first match (or the
// oldest binding on a miss) is selected along the chain and the list shifts
// down by one cell to move it to the front. The result sits in an output
// register, so a new request is taken while the previous result waits.
// No new request is taken while the previous one is in the lookup state.
// If the receiver stalls with a result still held, the block takes one more
// request and then holds it in the lookup state until the output register
// frees, so tready stays low meanwhile.
// Reset (synchronous, active low) puts unit i at rank i with no sampler and
// all modes zero, and empties the output register. No clearing pass.
`default_nettype none
module texture_unit_lru_binder #(
    parameter int UNIT_COUNT = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [15:0] sampler_id, [18:16] dflt_filter, [20:19] default_clamp_u,
    // [22:21] default_clamp_v, [25:23] texture_filter,
    // [27:26] texture_clamp_u, [29:28] texture_clamp_v, [31:30] zero
    input  wire logic [tulb_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // [3:0] unit, [4] rebound, [5] victim_had_sampler, [7:6] zero
    output logic [tulb_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata
);
    import tulb_pkg::*;
`include "texture_unit_lru_binder_defines.svh"

    localparam int UNIT_W = (UNIT_COUNT > 1) ? $clog2(UNIT_COUNT) : 1;

    t_state                r_state;
    t_state                n_state;
    t_mode                 r_key;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  w_accept;
    logic                  w_update;

    logic              w_found    [0:UNIT_COUNT];
    t_mode             w_sel_mode [0:UNIT_COUNT];
    logic [UNIT_W-1:0] w_sel_unit [0:UNIT_COUNT];
    t_mode             w_mode     [0:UNIT_COUNT-1];
    logic [UNIT_W-1:0] w_unit     [0:UNIT_COUNT-1];
    t_mode             w_shift_mode [0:UNIT_COUNT-1];
    logic [UNIT_W-1:0] w_shift_unit [0:UNIT_COUNT-1];
    t_mode             w_front_mode;
    logic              w_miss;
    logic              w_victim;
    logic [UNIT_W+OUT_UNIT_W-1:0] w_unit_ext;
    logic [FILTER_W-1:0] w_cu;
    logic [FILTER_W-1:0] w_cv;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    // Latch the request and resolve its modes
    assign w_cu = resolve_mode({1'b0, i_s_axis_tdata[20:19]}, {1'b0, i_s_axis_tdata[27:26]});
    assign w_cv = resolve_mode({1'b0, i_s_axis_tdata[22:21]}, {1'b0, i_s_axis_tdata[29:28]});
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key.sampler <= i_s_axis_tdata[15:0];
            r_key.filter  <= resolve_mode(i_s_axis_tdata[18:16], i_s_axis_tdata[25:23]);
            r_key.clamp_u <= w_cu[CLAMP_W-1:0];
            r_key.clamp_v <= w_cv[CLAMP_W-1:0];
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state; update the chain only when the output register is free
    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        w_update        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    w_update = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Binding chain: rank 0 is the most recently used
    assign w_found[0]    = 1'b0;
    assign w_sel_mode[0] = '0;
    assign w_sel_unit[0] = '0;

    genvar g;
    generate
        for (g = 0; g < UNIT_COUNT; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_shift_mode[g] = w_front_mode;
                assign w_shift_unit[g] = w_sel_unit[UNIT_COUNT];
            end else begin : g_body
                assign w_shift_mode[g] = w_mode[g-1];
                assign w_shift_unit[g] = w_unit[g-1];
            end
            tulb_cell #(
                .UNIT_W     (UNIT_W),
                .RESET_UNIT (g),
                .IS_LAST    (g == UNIT_COUNT - 1)
            ) u_cell (
                .i_clk                (i_clk),
                .i_rst_n              (i_rst_n),
                .i_update             (w_update),
                .i_key                (r_key),
                .i_found              (w_found[g]),
                .i_shift_mode         (w_shift_mode[g]),
                .i_shift_unit         (w_shift_unit[g]),
                .i_sel_mode           (w_sel_mode[g]),
                .i_sel_unit           (w_sel_unit[g]),
                .o_found              (w_found[g+1]),
                .o_sel_mode           (w_sel_mode[g+1]),
                .o_sel_unit           (w_sel_unit[g+1]),
                .o_mode               (w_mode[g]),
                .o_unit               (w_unit[g])
            );
        end
    endgenerate

    // Front entry: a real key rebinds with its own modes, a null key
    // keeps the selected binding's modes with no sampler
    always_comb begin
        if (r_key.sampler != '0) begin
            w_front_mode = r_key;
        end else begin
            w_front_mode         = w_sel_mode[UNIT_COUNT];
            w_front_mode.sampler = '0;
        end
    end

    assign w_miss     = !w_found[UNIT_COUNT];
    assign w_victim   = w_miss && (w_mode[UNIT_COUNT-1].sampler != '0);
    assign w_unit_ext = {{OUT_UNIT_W{1'b0}}, w_sel_unit[UNIT_COUNT]};

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_update) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_out_data <= {2'b00, w_victim, w_miss, w_unit_ext[OUT_UNIT_W-1:0]};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Checks
    `TULB_ASSERT_NOW(a_victim_needs_rebind, i_clk, i_rst_n, r_out_valid && r_out_data[5], r_out_data[4])
    `TULB_ASSERT_NEXT(a_accept_starts_lookup, i_clk, i_rst_n, w_accept, r_state == ST_LOOK)
    `TULB_ASSERT_NEXT(a_update_fills_output, i_clk, i_rst_n, w_update, r_out_valid && (r_state == ST_IDLE))
    `TULB_ASSERT_NOW(a_no_update_on_stall, i_clk, i_rst_n, r_out_valid && !i_m_axis_tready, !w_update)

endmodule
`default_nettype wire

### verif/tb_texture_unit_lru_binder.sv
`default_nettype none
module tb_texture_unit_lru_binder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNIT_COUNT    = 16;
    localparam int RANDOM_ITEMS  = 1225;
    localparam int QUIET_TAIL    = 150;
    localparam int POOL_SIZE     = 20;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_AT_ITEM  = 400;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int DRAIN_CYCLES  = 20;

    // Sampler tag 0 binds no texture
    localparam logic [tulb_pkg::SAMPLER_W-1:0] NO_SAMPLER = '0;
    // Mode encodings shared by filter and both address modes
    localparam logic [tulb_pkg::FILTER_W-1:0] MODE_UNDEFINED = 3'd0;
    localparam logic [tulb_pkg::FILTER_W-1:0] MODE_FALLBACK  = 3'd1;

    typedef struct packed {
        logic       victim;
        logic       rebound;
        logic [3:0] unit;
    } t_bind_result;

    // LRU list of unit bindings with the queue of predicted results
    class t_binding_tracker;
        tulb_pkg::t_mode slot_key[UNIT_COUNT];
        int              slot_unit[UNIT_COUNT];
        t_bind_result    expected_units[$];
        int              errors;

        function new();
            for (int i = 0; i < UNIT_COUNT; i++) begin
                slot_key[i]  = '0;
                slot_unit[i] = i;
            end
            errors = 0;
        endfunction

        // Default first, then the texture's own value, then none/clamp
        function logic [2:0] pick_mode(input logic [2:0] dflt, input logic [2:0] own);
            if (dflt != MODE_UNDEFINED) return dflt;
            if (own != MODE_UNDEFINED) return own;
            return MODE_FALLBACK;
        endfunction

        function void note_request(input logic [tulb_pkg::IN_DATA_W-1:0] word);
            tulb_pkg::t_mode key;
            tulb_pkg::t_mode moved;
            t_bind_result    res;
            int              hit;
            int              moved_unit;
            hit = -1;
            res = '0;
            key = '0;
            key.sampler = word[15:0];
            if (key.sampler == NO_SAMPLER) begin
                // Reuse the most recent binding with no sampler
                for (int i = 0; i < UNIT_COUNT; i++)
                    if (hit < 0 && slot_key[i].sampler == NO_SAMPLER) hit = i;
                if (hit < 0) begin
                    hit = UNIT_COUNT - 1;
                    res.rebound = 1'b1;
                    res.victim  = 1'b1;
                    slot_key[hit].sampler = NO_SAMPLER;
                end
            end else begin
                key.filter  = pick_mode(word[18:16], word[25:23]);
                key.clamp_u = 2'(pick_mode(3'(word[20:19]), 3'(word[27:26])));
                key.clamp_v = 2'(pick_mode(3'(word[22:21]), 3'(word[29:28])));
                // Lowest rank with the same sampler and modes wins
                for (int i = 0; i < UNIT_COUNT; i++)
                    if (hit < 0 && slot_key[i] == key) hit = i;
                if (hit < 0) begin
                    hit = UNIT_COUNT - 1;
                    res.rebound = 1'b1;
                    res.victim  = (slot_key[hit].sampler != NO_SAMPLER);
                    slot_key[hit] = key;
                end
            end
            res.unit = 4'(slot_unit[hit]);
            expected_units = {expected_units, res};
            // Move the chosen binding to the front
            moved      = slot_key[hit];
            moved_unit = slot_unit[hit];
            for (int i = hit; i > 0; i--) begin
                slot_key[i]  = slot_key[i-1];
                slot_unit[i] = slot_unit[i-1];
            end
            slot_key[0]  = moved;
            slot_unit[0] = moved_unit;
        endfunction

        function void check_result(input logic [tulb_pkg::OUT_DATA_W-1:0] word);
            t_bind_result want;
            if (expected_units.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, word);
                errors++;
                return;
            end
            want = expected_units.pop_front();
            if (word[3:0] !== want.unit) begin
                $display("%0t: unit expected %0d actual %0d", $time, want.unit, word[3:0]);
                errors++;
            end
            if (word[4] !== want.rebound) begin
                $display("%0t: rebound expected %0b actual %0b", $time, want.rebound, word[4]);
                errors++;
            end
            if (word[5] !== want.victim) begin
                $display("%0t: victim_had_sampler expected %0b actual %0b",
                         $time, want.victim, word[5]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_units.size();
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_s_axis_tvalid;
    logic                             o_s_axis_tready;
    // [15:0] sampler_id, [18:16] dflt_filter, [20:19] default_clamp_u,
    // [22:21] default_clamp_v, [25:23] texture_filter,
    // [27:26] texture_clamp_u, [29:28] texture_clamp_v, [31:30] zero
    logic [tulb_pkg::IN_DATA_W-1:0]   i_s_axis_tdata;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready;
    // [3:0] unit, [4] rebound, [5] victim_had_sampler, [7:6] zero
    logic [tulb_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata;

    t_binding_tracker tracker;
    bit             idle_on;
    bit             hold_req;
    bit             holding;
    int             quiet_cycles;

    texture_unit_lru_binder #(
        .UNIT_COUNT(UNIT_COUNT)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [tulb_pkg::IN_DATA_W-1:0] pack_request(
        input logic [15:0] sid,
        input logic [2:0]  df,
        input logic [1:0]  dcu,
        input logic [1:0]  dcv,
        input logic [2:0]  tf,
        input logic [1:0]  tcu,
        input logic [1:0]  tcv
    );
        return {2'b00, tcv, tcu, tf, dcv, dcu, df, sid};
    endfunction

    // Offer one word, after an optional gap, and hold it until taken
    task automatic send_word(input logic [tulb_pkg::IN_DATA_W-1:0] word);
        int gap;
        gap = 0;
        if (idle_on && !holding && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Receiver: random stall bursts and one long hold-off
    initial begin
        int stall;
        int hold;
        stall = 0;
        hold  = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold     = LONG_HOLD;
                holding  = 1'b1;
            end
            if (hold > 0) begin
                hold--;
                if (hold == 0) holding = 1'b0;
                i_m_axis_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                stall = $urandom_range(1, 17) - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Note taken requests and check returned words
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) tracker.note_request(i_s_axis_tdata);
            if (o_m_axis_tvalid && i_m_axis_tready) tracker.check_result(o_m_axis_tdata);
        end
    end

    // Stop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("FAIL texture_unit_lru_binder");
                $finish;
            end
        end
    end

    initial begin
        logic [tulb_pkg::IN_DATA_W-1:0] pool[POOL_SIZE];
        logic [tulb_pkg::IN_DATA_W-1:0] word;
        int                             pick;
        int                             slot;
        tracker         = new();
        quiet_cycles    = 0;
        idle_on         = 1'b1;
        hold_req        = 1'b0;
        holding         = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Null request right after reset hits the front binding
        send_word(pack_request(NO_SAMPLER, 3'd0, 2'd0, 2'd0, 3'd0, 2'd0, 2'd0));
        // All modes undefined resolve to none/clamp
        send_word(pack_request(16'd1, 3'd0, 2'd0, 2'd0, 3'd0, 2'd0, 2'd0));
        send_word(pack_request(16'd1, 3'd1, 2'd1, 2'd1, 3'd0, 2'd0, 2'd0));
        send_word(pack_request(16'd1, 3'd0, 2'd0, 2'd0, 3'd1, 2'd1, 2'd1));
        // Same sampler with another filter is a separate binding
        send_word(pack_request(16'd1, 3'd7, 2'd0, 2'd0, 3'd0, 2'd0, 2'd0));
        // Defaults at their top, then the same modes from the texture
        send_word(pack_request(16'hFFFF, 3'd7, 2'd3, 2'd3, 3'd0, 2'd0, 2'd0));
        send_word(pack_request(16'hFFFF, 3'd0, 2'd0, 2'd0, 3'd7, 2'd3, 2'd3));
        // Defined defaults override the texture's modes
        send_word(pack_request(16'd2, 3'd2, 2'd2, 2'd2, 3'd7, 2'd3, 2'd3));
        // Null request ignores every mode field
        send_word(pack_request(NO_SAMPLER, 3'd7, 2'd3, 2'd3, 3'd7, 2'd3, 2'd3));
        // Give every unit but the null binding a real sampler
        for (int k = 0; k < 12; k++)
            send_word(pack_request(16'(16 + k), 3'($urandom()), 2'($urandom()),
                                   2'($urandom()), 3'($urandom()), 2'($urandom()),
                                   2'($urandom())));
        // Null requests reuse the one binding still holding no sampler
        send_word(pack_request(NO_SAMPLER, 3'd0, 2'd0, 2'd0, 3'd0, 2'd0, 2'd0));
        send_word(pack_request(NO_SAMPLER, 3'd5, 2'd1, 2'd2, 3'd3, 2'd0, 2'd1));
        send_word(pack_request(16'd3, 3'd0, 2'd0, 2'd0, 3'd0, 2'd0, 2'd0));

        // Working set of requests, slightly larger than the unit count
        for (int k = 0; k < POOL_SIZE; k++)
            pool[k] = (32'($urandom()) & 32'h3FFF_0000) | 32'($urandom_range(1, 65535));

        for (int r = 0; r < RANDOM_ITEMS; r++) begin
            idle_on = (r < RANDOM_ITEMS - QUIET_TAIL) && ((r / 120) % 3 != 2);
            if (r == HOLD_AT_ITEM) hold_req = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                word = 32'($urandom()) & 32'h3FFF_0000;
            end else if (pick < 30) begin
                word = 32'($urandom()) & 32'h3FFF_FFFF;
            end else begin
                slot = $urandom_range(0, POOL_SIZE - 1);
                if ($urandom_range(0, 99) < 3)
                    pool[slot] = (32'($urandom()) & 32'h3FFF_0000)
                               | 32'($urandom_range(1, 65535));
                word = pool[slot];
                // Vary texture modes hidden behind a defined default
                if (word[18:16] != MODE_UNDEFINED) word[25:23] = 3'($urandom());
                if (word[20:19] != 2'(MODE_UNDEFINED)) word[27:26] = 2'($urandom());
                if (word[22:21] != 2'(MODE_UNDEFINED)) word[29:28] = 2'($urandom());
            end
            send_word(word);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("PASS texture_unit_lru_binder");
        else
            $display("FAIL texture_unit_lru_binder");
        $finish;
    end

endmodule
`default_nettype wire
